[src/wtg_pkg.sv]
// ----------------------------------------------------------------------------
// Waveform target generator package
// Shared types, register indexes and the sine table function.
// ----------------------------------------------------------------------------
package wtg_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int TIME_W     = 64;
    localparam int PERIOD_W   = 30;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_W    = 16;
    localparam int PROD_W     = VALUE_W + ENTRY_W;
    localparam int CNT_W      = $clog2(TIME_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [PERIOD_W-1:0] MAX_PERIOD_US = PERIOD_W'(1000000000);

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US = 2'd3;

    typedef enum logic [1:0] {
        MODE_CONST  = 2'd0,
        MODE_SINE   = 2'd1,
        MODE_SQUARE = 2'd2
    } wave_mode_t;

    typedef enum logic [1:0] {
        KIND_CONST,
        KIND_SINE,
        KIND_SQUARE
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_INDEX,
        ST_ROM,
        ST_MULT,
        ST_ROUND,
        ST_FINISH
    } state_t;

    localparam longint C1 = 64'sd1686629713;
    localparam longint C3 = -64'sd693598668;
    localparam longint C5 = 64'sd85569306;
    localparam longint C7 = -64'sd5026995;
    localparam longint C9 = 64'sd172272;

    function automatic longint mul_q30(input longint a, input longint b);
        longint m;
        longint p;
        m = (a < 0) ? -a : a;
        p = (m * b) >>> 30;
        return (a < 0) ? -p : p;
    endfunction

    function automatic longint quarter_sine(input longint x);
        longint x2;
        longint y;
        longint r;
        x2 = (x * x) >>> 30;
        y = C9;
        y = mul_q30(y, x2) + C7;
        y = mul_q30(y, x2) + C5;
        y = mul_q30(y, x2) + C3;
        y = mul_q30(y, x2) + C1;
        y = mul_q30(y, x);
        if (y < 0)
        begin
            y = 0;
        end
        r = (y + (64'sd1 <<< 14)) >>> 15;
        if (r > 32767)
        begin
            r = 32767;
        end
        return r;
    endfunction

    function automatic logic signed [ENTRY_W-1:0] sine_entry(input int i);
        longint q;
        longint r;
        longint f;
        longint s;
        q = ((4 * longint'(i)) / SINE_DEPTH) & 3;
        r = (4 * longint'(i)) % SINE_DEPTH;
        f = (r <<< 30) / SINE_DEPTH;
        if (q == 1 || q == 3)
        begin
            f = (64'sd1 <<< 30) - f;
        end
        s = quarter_sine(f);
        if (q >= 2)
        begin
            s = -s;
        end
        return ENTRY_W'(s);
    endfunction

endpackage

[src/waveform_target_generator.sv]
// ----------------------------------------------------------------------------
// Waveform target generator
// Produces one Q16.16 setpoint per sample request: constant, sine or square.
// ----------------------------------------------------------------------------
// Usage: a sample request (now_us, restart) enters on in_valid/in_ready and
// one target_value leaves on out_valid/out_ready for every request.
// Configuration registers are written through cfg_write/cfg_index/cfg_data
// while no request is in flight.
// The phase comes from one shared 31-bit subtract and compare unit: 64 steps
// of restoring division give the elapsed time modulo the period, and 10 more
// steps give the sine table index. A constant result goes straight to the
// finish step, a square result follows the division, and a sine result also
// needs the index steps, table read, multiply, rounding and the saturating add.
// Requests are taken one at a time: the next request is taken only after the
// previous one has reached its finish step.
// A finished result waits in the output register; the block goes back to
// idle and takes the next request while it waits, and a second result is
// held in its last step until the receiver takes the first.
// Reset clears the configuration registers, the sequencer and the waveform
// start time to zero.
// ----------------------------------------------------------------------------
module waveform_target_generator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [wtg_pkg::TIME_W-1:0]            now_us,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [wtg_pkg::VALUE_W-1:0]    target_value,
    input  logic                                  cfg_write,
    input  logic [wtg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wtg_pkg::VALUE_W-1:0]           cfg_data
);

    wtg_pkg::state_t                             state_reg;
    wtg_pkg::state_t                             state_next;
    wtg_pkg::kind_t                              kind_reg;
    wtg_pkg::kind_t                              kind_next;
    logic [1:0]                                  wave_mode_reg;
    logic signed [wtg_pkg::VALUE_W-1:0]          amplitude_reg;
    logic signed [wtg_pkg::VALUE_W-1:0]          offset_reg;
    logic [wtg_pkg::PERIOD_W-1:0]                period_reg;
    logic [wtg_pkg::TIME_W-1:0]                  start_time_reg;
    logic [wtg_pkg::CNT_W-1:0]                   cnt_reg;
    logic                                        out_valid_reg;
    logic signed [wtg_pkg::VALUE_W-1:0]          out_value_reg;

    logic [wtg_pkg::TIME_W-1:0]                  elapsed_reg;
    logic [wtg_pkg::TIME_W-1:0]                  elapsed_next;
    logic [wtg_pkg::PERIOD_W-1:0]                rem_reg;
    logic [wtg_pkg::PERIOD_W-1:0]                rem_next;
    logic [wtg_pkg::IDX_W-1:0]                   idx_reg;
    logic signed [wtg_pkg::ENTRY_W-1:0]          rom_data_reg;
    logic signed [wtg_pkg::PROD_W-1:0]           prod_reg;
    logic signed [wtg_pkg::VALUE_W:0]            scaled_reg;

    logic                                        accept;
    logic                                        out_fire;
    logic                                        shift_bit;
    logic [wtg_pkg::PERIOD_W:0]                  trial;
    logic [wtg_pkg::PERIOD_W+1:0]                diff;
    logic                                        ge;
    logic signed [wtg_pkg::PROD_W-1:0]           rounded;
    logic signed [wtg_pkg::VALUE_W:0]            addend;
    logic signed [wtg_pkg::VALUE_W+1:0]          sum;
    logic signed [wtg_pkg::VALUE_W-1:0]          sat_sum;
    logic signed [wtg_pkg::VALUE_W-1:0]          result;

    logic signed [wtg_pkg::ENTRY_W-1:0]          sine_rom [wtg_pkg::SINE_DEPTH];

    for (genvar g = 0; g < wtg_pkg::SINE_DEPTH; g++)
    begin : g_rom
        assign sine_rom[g] = wtg_pkg::sine_entry(g);
    end

    // Shared subtract and compare unit.
    always_comb
    begin
        shift_bit = (state_reg == wtg_pkg::ST_DIVIDE) ? elapsed_reg[wtg_pkg::TIME_W-1] : 1'b0;
        trial     = {rem_reg, shift_bit};
        diff      = {1'b0, trial} - {2'b00, period_reg};
        ge        = ~diff[wtg_pkg::PERIOD_W+1];
        rem_next  = ge ? diff[wtg_pkg::PERIOD_W-1:0] : trial[wtg_pkg::PERIOD_W-1:0];
    end

    always_comb
    begin
        elapsed_next = restart ? '0 : now_us - start_time_reg;
        if (period_reg == '0 || period_reg > wtg_pkg::MAX_PERIOD_US)
        begin
            kind_next = wtg_pkg::KIND_CONST;
        end
        else
        begin
            unique case (wave_mode_reg)
                wtg_pkg::MODE_SINE:   kind_next = wtg_pkg::KIND_SINE;
                wtg_pkg::MODE_SQUARE: kind_next = wtg_pkg::KIND_SQUARE;
                default:              kind_next = wtg_pkg::KIND_CONST;
            endcase
        end
    end

    always_comb
    begin
        rounded = prod_reg + (prod_reg[wtg_pkg::PROD_W-1] ? wtg_pkg::PROD_W'(16383)
                                                          : wtg_pkg::PROD_W'(16384));
        addend  = (kind_reg == wtg_pkg::KIND_SINE) ? scaled_reg
                                                   : {amplitude_reg[wtg_pkg::VALUE_W-1],
                                                      amplitude_reg};
        sum     = {addend[wtg_pkg::VALUE_W], addend}
                  + {{2{offset_reg[wtg_pkg::VALUE_W-1]}}, offset_reg};
        if (!sum[wtg_pkg::VALUE_W+1] && (sum[wtg_pkg::VALUE_W] || sum[wtg_pkg::VALUE_W-1]))
        begin
            sat_sum = {1'b0, {(wtg_pkg::VALUE_W-1){1'b1}}};
        end
        else if (sum[wtg_pkg::VALUE_W+1]
                 && !(sum[wtg_pkg::VALUE_W] && sum[wtg_pkg::VALUE_W-1]))
        begin
            sat_sum = {1'b1, {(wtg_pkg::VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_sum = sum[wtg_pkg::VALUE_W-1:0];
        end
        unique case (kind_reg)
            wtg_pkg::KIND_SINE:   result = sat_sum;
            wtg_pkg::KIND_SQUARE: result = ge ? offset_reg : sat_sum;
            default:              result = amplitude_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wtg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (kind_next == wtg_pkg::KIND_CONST) ? wtg_pkg::ST_FINISH
                                                                    : wtg_pkg::ST_DIVIDE;
                end
            end
            wtg_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (kind_reg == wtg_pkg::KIND_SINE) ? wtg_pkg::ST_INDEX
                                                                  : wtg_pkg::ST_FINISH;
                end
            end
            wtg_pkg::ST_INDEX:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = wtg_pkg::ST_ROM;
                end
            end
            wtg_pkg::ST_ROM:    state_next = wtg_pkg::ST_MULT;
            wtg_pkg::ST_MULT:   state_next = wtg_pkg::ST_ROUND;
            wtg_pkg::ST_ROUND:  state_next = wtg_pkg::ST_FINISH;
            wtg_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = wtg_pkg::ST_IDLE;
                end
            end
            default:            state_next = wtg_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready     = (state_reg == wtg_pkg::ST_IDLE);
        accept       = in_ready && in_valid;
        out_fire     = (state_reg == wtg_pkg::ST_FINISH) && (!out_valid_reg || out_ready);
        out_valid    = out_valid_reg;
        target_value = out_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wtg_pkg::ST_IDLE;
            kind_reg       <= wtg_pkg::KIND_CONST;
            wave_mode_reg  <= '0;
            amplitude_reg  <= '0;
            offset_reg     <= '0;
            period_reg     <= '0;
            start_time_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    wtg_pkg::REG_WAVE_MODE: wave_mode_reg <= cfg_data[1:0];
                    wtg_pkg::REG_AMPLITUDE: amplitude_reg <= cfg_data;
                    wtg_pkg::REG_OFFSET:    offset_reg    <= cfg_data;
                    wtg_pkg::REG_PERIOD_US: period_reg    <= cfg_data[wtg_pkg::PERIOD_W-1:0];
                    default:                period_reg    <= period_reg;
                endcase
            end
            if (accept)
            begin
                kind_reg <= kind_next;
                cnt_reg  <= wtg_pkg::CNT_W'(wtg_pkg::TIME_W - 1);
                if (restart)
                begin
                    start_time_reg <= now_us;
                end
            end
            else if (state_reg == wtg_pkg::ST_DIVIDE && cnt_reg == '0)
            begin
                cnt_reg <= wtg_pkg::CNT_W'(wtg_pkg::IDX_W - 1);
            end
            else if (state_reg == wtg_pkg::ST_DIVIDE || state_reg == wtg_pkg::ST_INDEX)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg <= elapsed_next;
            rem_reg     <= '0;
        end
        if (state_reg == wtg_pkg::ST_DIVIDE)
        begin
            elapsed_reg <= {elapsed_reg[wtg_pkg::TIME_W-2:0], 1'b0};
            rem_reg     <= rem_next;
        end
        if (state_reg == wtg_pkg::ST_INDEX)
        begin
            rem_reg <= rem_next;
            idx_reg <= {idx_reg[wtg_pkg::IDX_W-2:0], ge};
        end
        if (state_reg == wtg_pkg::ST_ROM)
        begin
            rom_data_reg <= sine_rom[idx_reg];
        end
        if (state_reg == wtg_pkg::ST_MULT)
        begin
            prod_reg <= amplitude_reg * rom_data_reg;
        end
        if (state_reg == wtg_pkg::ST_ROUND)
        begin
            scaled_reg <= rounded[wtg_pkg::PROD_W-1:15];
        end
        if (out_fire)
        begin
            out_value_reg <= result;
        end
    end

endmodule

[src/wtg_checker.sv]
// ----------------------------------------------------------------------------
// Waveform target generator checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module wtg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [wtg_pkg::VALUE_W-1:0]    target_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_value))
        else $error("Result changed or dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Request taken while the previous one is in work.");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("Ready dropped without an accepted request.");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("Result appeared without a request in work.");

endmodule

bind waveform_target_generator wtg_checker u_wtg_checker (.*);
